[rtl/bwb_pkg.sv]
// Package for the Bayer white balance gain block: widths, register codes,
// configuration and queue item types. No dependencies.
package bwb_pkg;

  localparam int unsigned MaxWidth   = 8192;
  localparam int unsigned MaxHeight  = 8192;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned SizeW      = 14;
  localparam int unsigned DepthW     = 4;
  localparam int unsigned LevelW     = 12;
  localparam int unsigned GainW      = 12;
  localparam int unsigned PixW       = 16;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 32;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned ProdW      = PixW + 1 + GainW + 1;
  localparam int unsigned SumW       = ProdW + 1;
  localparam int unsigned ShiftW     = 3;

  localparam logic [DepthW-1:0] DepthMin = DepthW'(8);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(12);
  localparam logic [PixW-1:0]   PixMask  = 16'hFFF0;
  localparam logic [PixW-1:0]   PixSat   = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_BIT_DEPTH    = 3'd2,
    REG_PEDESTAL     = 3'd3,
    REG_GAIN_RED     = 3'd4,
    REG_GAIN_GREEN   = 3'd5,
    REG_GAIN_BLUE    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [SizeW-1:0]  frame_width;
    logic [SizeW-1:0]  frame_height;
    logic [DepthW-1:0] bit_depth;
    logic [LevelW-1:0] pedestal;
    logic [GainW-1:0]  gain_red;
    logic [GainW-1:0]  gain_green;
    logic [GainW-1:0]  gain_blue;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0]  raw;
    logic [GainW-1:0] gain;
    logic             eor;
    logic             eof;
  } item_t;

endpackage

[rtl/bwb_regs.sv]
// Configuration register file behind the APB-style port.
// Depends on bwb_pkg.
module bwb_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bwb_pkg::AddrW-1:0] paddr,
  input  logic [bwb_pkg::DataW-1:0] pwdata,
  output logic [bwb_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output bwb_pkg::cfg_t             cfg_o
);
  import bwb_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FRAME_WIDTH:  cfg_d.frame_width  = pwdata[SizeW-1:0];
        REG_FRAME_HEIGHT: cfg_d.frame_height = pwdata[SizeW-1:0];
        REG_BIT_DEPTH:    cfg_d.bit_depth    = pwdata[DepthW-1:0];
        REG_PEDESTAL:     cfg_d.pedestal     = pwdata[LevelW-1:0];
        REG_GAIN_RED:     cfg_d.gain_red     = pwdata[GainW-1:0];
        REG_GAIN_GREEN:   cfg_d.gain_green   = pwdata[GainW-1:0];
        REG_GAIN_BLUE:    cfg_d.gain_blue    = pwdata[GainW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:  prdata = DataW'(cfg_q.frame_width);
      REG_FRAME_HEIGHT: prdata = DataW'(cfg_q.frame_height);
      REG_BIT_DEPTH:    prdata = DataW'(cfg_q.bit_depth);
      REG_PEDESTAL:     prdata = DataW'(cfg_q.pedestal);
      REG_GAIN_RED:     prdata = DataW'(cfg_q.gain_red);
      REG_GAIN_GREEN:   prdata = DataW'(cfg_q.gain_green);
      REG_GAIN_BLUE:    prdata = DataW'(cfg_q.gain_blue);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= SizeW'(640);
      cfg_q.frame_height <= SizeW'(480);
      cfg_q.bit_depth    <= DepthW'(10);
      cfg_q.pedestal     <= '0;
      cfg_q.gain_red     <= GainW'(512);
      cfg_q.gain_green   <= GainW'(256);
      cfg_q.gain_blue    <= GainW'(512);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/bwb_front.sv]
// Front end: raster position counters, colour site and gain selection.
// Depends on bwb_pkg.
module bwb_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bwb_pkg::cfg_t            cfg_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [bwb_pkg::PixW-1:0] raw_pixel_i,
  output logic                     push_o,
  output bwb_pkg::item_t           item_o
);
  import bwb_pkg::*;

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [SizeW-1:0] w_clamp, h_clamp;
  logic [ColW-1:0]  col_last;
  logic [RowW-1:0]  row_last;
  logic             eor, row_end;

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      w_clamp = SizeW'(1);
    end else if (cfg_i.frame_width > SizeW'(MaxWidth)) begin
      w_clamp = SizeW'(MaxWidth);
    end else begin
      w_clamp = cfg_i.frame_width;
    end
    if (cfg_i.frame_height == '0) begin
      h_clamp = SizeW'(1);
    end else if (cfg_i.frame_height > SizeW'(MaxHeight)) begin
      h_clamp = SizeW'(MaxHeight);
    end else begin
      h_clamp = cfg_i.frame_height;
    end
  end

  assign col_last = ColW'(w_clamp - SizeW'(1));
  assign row_last = RowW'(h_clamp - SizeW'(1));
  assign eor      = col_q >= col_last;
  assign row_end  = row_q >= row_last;
  assign push_o   = in_valid_i & in_ready_i;

  always_comb begin
    item_o.raw = raw_pixel_i;
    item_o.eor = eor;
    item_o.eof = eor & row_end;
    case ({row_q[0], col_q[0]})
      2'b00:   item_o.gain = cfg_i.gain_red;
      2'b11:   item_o.gain = cfg_i.gain_blue;
      default: item_o.gain = cfg_i.gain_green;
    endcase
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (eor) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

[rtl/bwb_fifo.sv]
// Short queue between front end and datapath.
// Depends on bwb_pkg.
module bwb_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bwb_pkg::item_t push_item_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output bwb_pkg::item_t pop_item_o
);
  import bwb_pkg::*;

  item_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoPtrW:0]   cnt_q, cnt_d;
  logic                do_pop;

  assign full_o     = cnt_q == (FifoPtrW+1)'(FifoDepth);
  assign empty_o    = cnt_q == '0;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_item_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + FifoPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + FifoPtrW'(1) : rd_q;
    cnt_d = cnt_q + (FifoPtrW+1)'(push_i) - (FifoPtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/bwb_back.sv]
// Datapath: black offset, gain multiply, clamp, mask, scale and saturate,
// ending in the output register. Depends on bwb_pkg.
module bwb_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bwb_pkg::cfg_t            cfg_i,
  input  logic                     empty_i,
  input  bwb_pkg::item_t           item_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [bwb_pkg::PixW-1:0] corrected_pixel_o,
  output logic                     end_of_row_o,
  output logic                     end_of_frame_o
);
  import bwb_pkg::*;

  logic [DepthW-1:0]       depth;
  logic [ShiftW-1:0]       shift;
  logic [PixW-1:0]         opb;
  logic signed [PixW:0]    diff;
  logic signed [ProdW-1:0] prod;
  logic signed [SumW-1:0]  sum;
  logic [PixW-1:0]         res;
  logic [PixW+3:0]         scaled;
  logic                    en;

  logic                    s1_valid_q;
  logic signed [ProdW-1:0] s1_prod_q;
  logic                    s1_eor_q, s1_eof_q;
  logic                    out_valid_q;
  logic [PixW-1:0]         pix_q;
  logic                    eor_q, eof_q;

  always_comb begin
    if (cfg_i.bit_depth < DepthMin) begin
      depth = DepthMin;
    end else if (cfg_i.bit_depth > DepthMax) begin
      depth = DepthMax;
    end else begin
      depth = cfg_i.bit_depth;
    end
  end

  assign shift = ShiftW'(DepthMax - depth);
  assign opb   = {cfg_i.pedestal, 4'b0} >> shift;
  assign diff  = $signed({1'b0, item_i.raw}) - $signed({1'b0, opb});
  assign prod  = ProdW'(diff) * $signed({{(ProdW-GainW){1'b0}}, item_i.gain});

  assign sum    = SumW'(s1_prod_q) + $signed({{(SumW-PixW-8){1'b0}}, opb, 8'b0});
  assign res    = sum[SumW-1] ? '0 : (sum[PixW+7:8] & PixMask);
  assign scaled = {4'b0, res} << shift;

  assign en          = ~out_valid_q | out_ready_i;
  assign pop_o       = en & ~empty_i;
  assign out_valid_o = out_valid_q;
  assign corrected_pixel_o = pix_q;
  assign end_of_row_o      = eor_q;
  assign end_of_frame_o    = eof_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q <= prod;
      s1_eor_q  <= item_i.eor;
      s1_eof_q  <= item_i.eof;
      pix_q     <= (|scaled[PixW+3:PixW]) ? PixSat : scaled[PixW-1:0];
      eor_q     <= s1_eor_q;
      eof_q     <= s1_eof_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= ~empty_i;
      out_valid_q <= s1_valid_q;
    end
  end

endmodule

[rtl/bayer_white_balance_gain.sv]
// Top level of the Bayer white balance gain block.
// Depends on bwb_pkg, bwb_regs, bwb_front, bwb_fifo and bwb_back.
//
// Takes one raw pixel per clock in raster order and returns one corrected
// pixel per clock while out_ready_i stays high, with end-of-row and
// end-of-frame flags. A pixel passes through the four-entry queue behind
// the position counters and the gain multiplier stage, whose result passes
// through clamp, scale and saturate into the output register. Input ready
// drops only when the queue is full, which happens once four beats have
// piled up behind a stalled output.
// Registers are written through the APB-style port and should only change
// while no pixels are in flight.
module bayer_white_balance_gain (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bwb_pkg::AddrW-1:0] paddr,
  input  logic [bwb_pkg::DataW-1:0] pwdata,
  output logic [bwb_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bwb_pkg::PixW-1:0]  raw_pixel_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bwb_pkg::PixW-1:0]  corrected_pixel_o,
  output logic                      end_of_row_o,
  output logic                      end_of_frame_o
);
  import bwb_pkg::*;

  cfg_t  cfg;
  item_t push_item, pop_item;
  logic  push, pop, full, empty;

  assign in_ready_o = ~full;

  bwb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bwb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .raw_pixel_i (raw_pixel_i),
    .push_o      (push),
    .item_o      (push_item)
  );

  bwb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .empty_o     (empty),
    .pop_i       (pop),
    .pop_item_o  (pop_item)
  );

  bwb_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .empty_i           (empty),
    .item_i            (pop_item),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .corrected_pixel_o (corrected_pixel_o),
    .end_of_row_o      (end_of_row_o),
    .end_of_frame_o    (end_of_frame_o)
  );

endmodule

[rtl/bwb_checker.sv]
// Port-level checks for the Bayer white balance gain block, bound to the
// top level. Depends on bwb_pkg and bayer_white_balance_gain.
module bwb_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     pready,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [bwb_pkg::PixW-1:0] corrected_pixel_o,
  input logic                     end_of_row_o,
  input logic                     end_of_frame_o
);
  import bwb_pkg::*;

  // output beat held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(corrected_pixel_o)
      && $stable(end_of_row_o) && $stable(end_of_frame_o))
    else $error("output beat changed while stalled");

  // last pixel of a frame is also last of its row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> end_of_row_o)
    else $error("end of frame without end of row");

  // no output beat can appear without an earlier accepted input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_valid_i && in_ready_o) && !$past(in_valid_i && in_ready_o, 2)
      && !$past(out_valid_o) && !$past(out_valid_o, 2) && !$past(out_valid_o, 3)
      && !$past(in_valid_i && in_ready_o, 3) |-> !out_valid_o)
    else $error("output beat with no input beat in flight");

  // queue never refuses input while the output side keeps draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i && $past(out_ready_i) && $past(out_ready_i, 2)
      && $past(out_ready_i, 3) && $past(out_ready_i, 4) |-> in_ready_o)
    else $error("input stalled with output draining");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind bayer_white_balance_gain bwb_checker u_bwb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .pready            (pready),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .corrected_pixel_o (corrected_pixel_o),
  .end_of_row_o      (end_of_row_o),
  .end_of_frame_o    (end_of_frame_o)
);
